>>> design/lru_key_value_cache_top_defines.svh
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_defines.svh
// Assertion macros for the LRU key-value cache. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked on every clock edge out of reset
`define LKVC_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("lkvc assertion failed");
// Implication checked on every clock edge out of reset
`define LKVC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT(name, expr)
`define LKVC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key-value cache modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int CAP_W       = 5;
  localparam int FUNC_W      = 1;
  localparam int KEY_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int CAP_RESET   = 16;

  localparam logic [FUNC_W-1:0] FUNC_GET = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] write_value;
  } lkvc_in_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
  } lkvc_out_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic upd;   // a transaction is accepted this cycle
    logic put;   // it is a put
    logic hit;   // its key sits in some cell
  } lkvc_ctrl_t;

endpackage

>>> design/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative LRU key-value cache built as a chain of recency cells.
// ----------------------------------------------------------------------------
//  Channel  Ports                              Direction
//  in       in_valid, in_stall, in_data        get/put request in
//  out      out_valid, out_stall, out_data     hit, read value, evicted out
//  cfg      cfg_wr_en, cfg_wr_data             capacity_in_use write
//
//  One transaction per cycle while in_stall is low; the result is registered and shows in the cycle after acceptance.
//  The rate is set by the combinational key search along the cell chain.
//  Cell 0 is most recently used; a hit or put shifts cells one step older.
//  Synchronous reset empties all cells at once; capacity resets to 16.
//  in_stall is high only while a result waits and out_stall is high.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lkvc_pkg::lkvc_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lkvc_pkg::lkvc_out_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data
);
  import lkvc_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [CAP_W-1:0]      cap_r;
  logic [CNT_W-1:0]      cap_eff;
  logic [CNT_W-1:0]      count_r, count_nxt, count_left;
  logic                  out_valid_r, out_valid_nxt;
  lkvc_out_t             out_data_r;
  logic                  accept;
  logic                  is_put;
  lkvc_ctrl_t            ctrl;
  logic [31:0]           key_ext, value_ext;
  logic [KEY_BITS-1:0]   search_key;
  logic [VALUE_BITS-1:0] wr_value;
  logic [VALUE_BITS-1:0] head_value;
  logic                  hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  evict;

  logic                  ent_valid [ENTRIES];
  logic [KEY_BITS-1:0]   ent_key   [ENTRIES];
  logic [VALUE_BITS-1:0] ent_value [ENTRIES];
  logic                  chain_match [ENTRIES+1];
  logic [VALUE_BITS-1:0] chain_value [ENTRIES+1];
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    match_vec;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_put   = (in_data.func == FUNC_PUT);

  assign key_ext    = 32'(in_data.key);
  assign value_ext  = 32'(in_data.write_value);
  assign search_key = key_ext[KEY_BITS-1:0];
  assign wr_value   = value_ext[VALUE_BITS-1:0];

  // Capacity register; its effective value is clamped to 1..ENTRIES
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RESET);
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign chain_match[ENTRIES] = 1'b0;
  assign chain_value[ENTRIES] = '0;
  assign hit       = chain_match[0];
  assign hit_value = chain_value[0];

  assign ctrl.upd = accept;
  assign ctrl.put = is_put;
  assign ctrl.hit = hit;

  // Entry entering the most recent position
  assign head_value = is_put ? wr_value : hit_value;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic                  p_valid;
      logic [KEY_BITS-1:0]   p_key;
      logic [VALUE_BITS-1:0] p_value;
      if (gi == 0) begin : g_head
        assign p_valid = 1'b1;
        assign p_key   = search_key;
        assign p_value = head_value;
      end else begin : g_body
        assign p_valid = ent_valid[gi-1];
        assign p_key   = ent_key[gi-1];
        assign p_value = ent_value[gi-1];
      end
      lkvc_cell #(
        .IDX        (gi),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cap        (cap_eff),
        .search_key (search_key),
        .prev_valid (p_valid),
        .prev_key   (p_key),
        .prev_value (p_value),
        .match_in   (chain_match[gi+1]),
        .value_in   (chain_value[gi+1]),
        .match_out  (chain_match[gi]),
        .value_out  (chain_value[gi]),
        .match_here (match_vec[gi]),
        .valid      (ent_valid[gi]),
        .key        (ent_key[gi]),
        .value      (ent_value[gi])
      );
      assign valid_vec[gi] = ent_valid[gi];
    end
  endgenerate

  // Fill level: a put keeps min(entries left after removal, cap-1) plus the new one
  assign count_left = count_r - CNT_W'(hit);
  assign evict      = is_put && (count_left >= cap_eff);

  always_comb begin
    count_nxt = count_r;
    if (accept && is_put) begin
      count_nxt = evict ? cap_eff : (count_left + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.hit        <= hit;
      out_data_r.read_value <= is_put ? '0 : VALUE_W'(hit_value);
      out_data_r.evicted    <= evict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LKVC_ASSERT(a_count_matches_cells, 32'(count_r) == 32'($countones(valid_vec)))
  `LKVC_ASSERT(a_cells_packed, (valid_vec & (valid_vec + ENTRIES'(1))) == '0)
  `LKVC_ASSERT(a_single_match, $onehot0(match_vec))
  `LKVC_ASSERT_NEXT(a_put_fills_head, accept && is_put, ent_valid[0])
  `LKVC_ASSERT(a_evict_no_data, !(out_valid_r && out_data_r.evicted) || (out_data_r.read_value == '0))

endmodule

>>> design/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency position of the cache. Holds one entry, compares it against
// the search key and takes its neighbor's entry when the list shifts.
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int IDX        = 0,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lkvc_pkg::lkvc_ctrl_t   ctrl,
  input  logic [CNT_W-1:0]       cap,
  input  logic [KEY_BITS-1:0]    search_key,
  input  logic                   prev_valid,
  input  logic [KEY_BITS-1:0]    prev_key,
  input  logic [VALUE_BITS-1:0]  prev_value,
  input  logic                   match_in,
  input  logic [VALUE_BITS-1:0]  value_in,
  output logic                   match_out,
  output logic [VALUE_BITS-1:0]  value_out,
  output logic                   match_here,
  output logic                   valid,
  output logic [KEY_BITS-1:0]    key,
  output logic [VALUE_BITS-1:0]  value
);
  import lkvc_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  shift;
  logic                  in_range;

  assign match_here = valid_r && (key_r == search_key);
  // match_in comes from the less recent side: match_out means the hit is here or older
  assign match_out  = match_here | match_in;
  assign value_out  = (match_here ? value_r : '0) | value_in;

  // Positions up to the hit (or all on a put miss) move one step older
  assign shift    = ctrl.upd && (ctrl.put || ctrl.hit) && (!ctrl.hit || match_out);
  assign in_range = CNT_W'(IDX) < cap;

  always_comb begin
    valid_nxt = valid_r;
    if (shift) begin
      valid_nxt = prev_valid;
    end
    // a put trims everything past capacity
    if (ctrl.upd && ctrl.put && !in_range) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;

endmodule
